>>> src/sfta_pkg.sv
// Shared types and constants for the strip/fan triangle assembler.
// No dependencies; every other file in src refers to it by scoped names.
package sfta_pkg;

  // Groups allowed between two terminators before the mesh is stopped
  localparam int unsigned GROUP_LIMIT = 65535;

  // Triangle queue between front and back
  localparam int unsigned QUEUE_DEPTH = 2;
  localparam int unsigned QUEUE_AW    = $clog2(QUEUE_DEPTH);

  // Limit register width
  localparam int unsigned LIMIT_W = 17;

  // Command codes
  typedef enum logic {
    CMD_HEADER = 1'b0,
    CMD_VERTEX = 1'b1
  } cmd_t;

  // Configuration register indexes
  typedef enum logic {
    REG_VERTEX_LIMIT = 1'b0,
    REG_NORMAL_LIMIT = 1'b1
  } reg_index_t;

  // Corner positions within a triangle
  typedef enum logic [1:0] {
    CORNER_A = 2'd0,
    CORNER_B = 2'd1,
    CORNER_C = 2'd2
  } corner_t;

  // One command vertex
  typedef struct packed {
    logic [15:0]        vertex;
    logic [15:0]        normal;
    logic signed [15:0] s;
    logic signed [15:0] t;
  } vrec_t;

  // One triangle ready to emit: corners in output order plus kept flags
  typedef struct packed {
    vrec_t [2:0] rec;
    logic [2:0]  kept;
  } tri_job_t;

  // Triangle transfer between stages
  typedef struct packed {
    logic     valid;
    tri_job_t job;
  } job_xfer_t;

endpackage

>>> src/sfta_front.sv
// Front end: accepts command items, tracks group state and forms triangles.
// Depends on sfta_pkg.
module sfta_front (
  input  logic                         clk,
  input  logic                         rst,
  input  logic                         accept,
  input  logic                         cmd,
  input  logic signed [15:0]           group_count,
  input  logic [15:0]                  vertex_id,
  input  logic [15:0]                  normal_id,
  input  logic signed [15:0]           tex_s,
  input  logic signed [15:0]           tex_t,
  input  logic [sfta_pkg::LIMIT_W-1:0] vertex_limit,
  input  logic [sfta_pkg::LIMIT_W-1:0] normal_limit,
  output sfta_pkg::job_xfer_t          push
);

  sfta_pkg::vrec_t first_record;
  sfta_pkg::vrec_t older_record;
  sfta_pkg::vrec_t newer_record;
  logic [15:0]     vertices_left;
  logic [15:0]     position_in_group;
  logic            fan_mode;
  logic [15:0]     groups_seen;
  logic            mesh_stopped;

  sfta_pkg::vrec_t cur_rec;
  logic            is_header;
  logic            is_term;
  logic            over_limit;
  logic            take_vertex;
  logic            emit;
  logic [15:0]     left_dec;
  sfta_pkg::vrec_t rec_a;
  sfta_pkg::vrec_t rec_b;

  function automatic logic corner_ok(sfta_pkg::vrec_t r,
                                     logic [sfta_pkg::LIMIT_W-1:0] vlim,
                                     logic [sfta_pkg::LIMIT_W-1:0] nlim);
    logic vok;
    logic nok;
    vok = {1'b0, r.vertex} < vlim;
    nok = {1'b0, r.normal} < nlim;
    return vok && nok;
  endfunction

  // Classify the item
  always_comb begin
    cur_rec     = '{vertex: vertex_id, normal: normal_id, s: tex_s, t: tex_t};
    is_header   = (cmd == sfta_pkg::CMD_HEADER);
    is_term     = (group_count == 16'sd0);
    over_limit  = mesh_stopped || (groups_seen >= 16'(sfta_pkg::GROUP_LIMIT));
    take_vertex = !is_header && !mesh_stopped && (vertices_left != 16'd0);
    emit        = take_vertex && (position_in_group >= 16'd2);
    left_dec    = vertices_left - 16'd1;
  end

  // Pick corner order: fan, even strip or odd strip
  always_comb begin
    if (fan_mode) begin
      rec_a = first_record;
      rec_b = newer_record;
    end else if (!position_in_group[0]) begin
      rec_a = older_record;
      rec_b = newer_record;
    end else begin
      rec_a = newer_record;
      rec_b = older_record;
    end
  end

  // Hand the triangle to the queue
  always_comb begin
    push.valid       = accept && emit;
    push.job.rec[0]  = rec_a;
    push.job.rec[1]  = rec_b;
    push.job.rec[2]  = cur_rec;
    push.job.kept[0] = corner_ok(rec_a, vertex_limit, normal_limit);
    push.job.kept[1] = corner_ok(rec_b, vertex_limit, normal_limit);
    push.job.kept[2] = corner_ok(cur_rec, vertex_limit, normal_limit);
  end

  // Group control state
  always_ff @(posedge clk) begin
    if (rst) begin
      vertices_left     <= '0;
      position_in_group <= '0;
      fan_mode          <= 1'b0;
      groups_seen       <= '0;
      mesh_stopped      <= 1'b0;
    end else if (accept) begin
      if (is_header) begin
        position_in_group <= '0;
        if (is_term) begin
          groups_seen   <= '0;
          mesh_stopped  <= 1'b0;
          vertices_left <= '0;
        end else if (over_limit) begin
          mesh_stopped  <= 1'b1;
          vertices_left <= '0;
        end else begin
          groups_seen   <= groups_seen + 16'd1;
          fan_mode      <= group_count[15];
          vertices_left <= group_count[15] ? 16'(-group_count) : 16'(group_count);
        end
      end else if (take_vertex) begin
        vertices_left     <= left_dec;
        position_in_group <= (left_dec == 16'd0) ? 16'd0 : position_in_group + 16'd1;
      end
    end
  end

  // Vertex history
  always_ff @(posedge clk) begin
    if (accept && take_vertex) begin
      if (position_in_group == 16'd0) begin
        first_record <= cur_rec;
      end
      older_record <= newer_record;
      newer_record <= cur_rec;
    end
  end

endmodule

>>> src/sfta_queue.sv
// Short triangle queue between the front and back ends.
// Depends on sfta_pkg.
module sfta_queue (
  input  logic                clk,
  input  logic                rst,
  input  sfta_pkg::job_xfer_t push,
  input  logic                pop,
  output sfta_pkg::job_xfer_t head,
  output logic                full
);

  sfta_pkg::tri_job_t               mem [sfta_pkg::QUEUE_DEPTH];
  logic [sfta_pkg::QUEUE_AW-1:0]    wr_ptr;
  logic [sfta_pkg::QUEUE_AW-1:0]    rd_ptr;
  logic [sfta_pkg::QUEUE_AW:0]      count;

  assign full       = (count == (sfta_pkg::QUEUE_AW+1)'(sfta_pkg::QUEUE_DEPTH));
  assign head.valid = (count != '0);
  assign head.job   = mem[rd_ptr];

  // Store incoming triangles
  always_ff @(posedge clk) begin
    if (push.valid) begin
      mem[wr_ptr] <= push.job;
    end
  end

  // Advance pointers and occupancy
  always_ff @(posedge clk) begin
    if (rst) begin
      wr_ptr <= '0;
      rd_ptr <= '0;
      count  <= '0;
    end else begin
      if (push.valid) begin
        wr_ptr <= (wr_ptr == sfta_pkg::QUEUE_AW'(sfta_pkg::QUEUE_DEPTH - 1)) ?
                  '0 : wr_ptr + 1'b1;
      end
      if (pop) begin
        rd_ptr <= (rd_ptr == sfta_pkg::QUEUE_AW'(sfta_pkg::QUEUE_DEPTH - 1)) ?
                  '0 : rd_ptr + 1'b1;
      end
      case ({push.valid, pop})
        2'b10:   count <= count + 1'b1;
        2'b01:   count <= count - 1'b1;
        default: count <= count;
      endcase
    end
  end

endmodule

>>> src/sfta_back.sv
// Back end: plays one queued triangle out as three corners, one per transfer.
// Depends on sfta_pkg.
module sfta_back (
  input  logic                clk,
  input  logic                rst,
  input  sfta_pkg::job_xfer_t head,
  output logic                pop,
  output logic                out_valid,
  input  logic                out_stall,
  output logic [15:0]         out_vertex,
  output logic [15:0]         out_normal,
  output logic signed [15:0]  out_s,
  output logic signed [15:0]  out_t,
  output logic [1:0]          corner,
  output logic                corner_kept,
  output logic                triangle_kept,
  output logic                last
);

  sfta_pkg::tri_job_t cur;
  logic               cur_valid;
  sfta_pkg::corner_t  pos;

  logic xfer;
  logic reload;

  // Load a new triangle when empty or when the last corner goes out
  assign xfer   = cur_valid && !out_stall;
  assign reload = !cur_valid || (xfer && (pos == sfta_pkg::CORNER_C));
  assign pop    = reload && head.valid;

  always_ff @(posedge clk) begin
    if (rst) begin
      cur_valid <= 1'b0;
      pos       <= sfta_pkg::CORNER_A;
    end else if (reload) begin
      cur_valid <= head.valid;
      pos       <= sfta_pkg::CORNER_A;
    end else if (xfer) begin
      case (pos)
        sfta_pkg::CORNER_A: pos <= sfta_pkg::CORNER_B;
        sfta_pkg::CORNER_B: pos <= sfta_pkg::CORNER_C;
        default:            pos <= sfta_pkg::CORNER_A;
      endcase
    end
  end

  always_ff @(posedge clk) begin
    if (pop) begin
      cur <= head.job;
    end
  end

  // Drive the current corner
  always_comb begin
    out_valid     = cur_valid;
    out_vertex    = cur.rec[pos].vertex;
    out_normal    = cur.rec[pos].normal;
    out_s         = cur.rec[pos].s;
    out_t         = cur.rec[pos].t;
    corner        = pos;
    corner_kept   = cur.kept[pos];
    last          = (pos == sfta_pkg::CORNER_C);
    triangle_kept = last && (&cur.kept);
  end

endmodule

>>> src/strip_fan_triangle_assembler_top.sv
// Top level of the strip/fan triangle assembler: limit registers and the
// front end, triangle queue and corner back end. Depends on sfta_pkg,
// sfta_front, sfta_queue and sfta_back.
//
// Turns a stream of strip/fan headers and command vertices into a flat list
// of triangle corners. One input item is taken per cycle whenever the
// two-entry triangle queue has room; headers, short groups and dropped items
// leave no result. Each vertex that closes a triangle yields three corner
// transfers, sent one per cycle from the output register while out_stall is
// low; a steady run of triangles is paced by the corner output. When idle,
// a vertex is queued, then loaded into the corner register. Write the limit
// registers only while no triangle is in flight.
module strip_fan_triangle_assembler_top (
  input  logic                         clk,
  input  logic                         rst,
  // command input
  input  logic                         in_valid,
  output logic                         in_stall,
  input  logic                         cmd,
  input  logic signed [15:0]           group_count,
  input  logic [15:0]                  vertex_id,
  input  logic [15:0]                  normal_id,
  input  logic signed [15:0]           tex_s,
  input  logic signed [15:0]           tex_t,
  // corner output
  output logic                         out_valid,
  input  logic                         out_stall,
  output logic [15:0]                  out_vertex,
  output logic [15:0]                  out_normal,
  output logic signed [15:0]           out_s,
  output logic signed [15:0]           out_t,
  output logic [1:0]                   corner,
  output logic                         corner_kept,
  output logic                         triangle_kept,
  output logic                         last,
  // configuration
  input  logic                         cfg_valid,
  output logic                         cfg_ready,
  input  logic                         cfg_index,
  input  logic [sfta_pkg::LIMIT_W-1:0] cfg_data
);

  logic [sfta_pkg::LIMIT_W-1:0] vertex_limit;
  logic [sfta_pkg::LIMIT_W-1:0] normal_limit;

  sfta_pkg::job_xfer_t push;
  sfta_pkg::job_xfer_t head;
  logic                q_full;
  logic                pop;
  logic                accept;

  assign cfg_ready = 1'b1;
  assign in_stall  = q_full;
  assign accept    = in_valid && !q_full;

  // Limit registers
  always_ff @(posedge clk) begin
    if (rst) begin
      vertex_limit <= sfta_pkg::LIMIT_W'(65536);
      normal_limit <= sfta_pkg::LIMIT_W'(65536);
    end else if (cfg_valid && cfg_ready) begin
      case (cfg_index)
        sfta_pkg::REG_VERTEX_LIMIT: vertex_limit <= cfg_data;
        sfta_pkg::REG_NORMAL_LIMIT: normal_limit <= cfg_data;
        default:                    vertex_limit <= vertex_limit;
      endcase
    end
  end

  sfta_front u_front (
    .clk          (clk),
    .rst          (rst),
    .accept       (accept),
    .cmd          (cmd),
    .group_count  (group_count),
    .vertex_id    (vertex_id),
    .normal_id    (normal_id),
    .tex_s        (tex_s),
    .tex_t        (tex_t),
    .vertex_limit (vertex_limit),
    .normal_limit (normal_limit),
    .push         (push)
  );

  sfta_queue u_queue (
    .clk  (clk),
    .rst  (rst),
    .push (push),
    .pop  (pop),
    .head (head),
    .full (q_full)
  );

  sfta_back u_back (
    .clk           (clk),
    .rst           (rst),
    .head          (head),
    .pop           (pop),
    .out_valid     (out_valid),
    .out_stall     (out_stall),
    .out_vertex    (out_vertex),
    .out_normal    (out_normal),
    .out_s         (out_s),
    .out_t         (out_t),
    .corner        (corner),
    .corner_kept   (corner_kept),
    .triangle_kept (triangle_kept),
    .last          (last)
  );

endmodule

>>> tb/sfta_corner_checker.sv
// Corner checker for the strip/fan triangle assembler: watches the command,
// corner and limit-register channels, predicts every corner and compares.
// Depends on sfta_pkg for the vertex record, command and corner codes.
`timescale 1ns / 1ps

module sfta_corner_checker (
  input  logic                         clk,
  input  logic                         rst,
  input  logic                         in_valid,
  input  logic                         in_stall,
  input  logic                         cmd,
  input  logic signed [15:0]           group_count,
  input  logic [15:0]                  vertex_id,
  input  logic [15:0]                  normal_id,
  input  logic signed [15:0]           tex_s,
  input  logic signed [15:0]           tex_t,
  input  logic                         out_valid,
  input  logic                         out_stall,
  input  logic [15:0]                  out_vertex,
  input  logic [15:0]                  out_normal,
  input  logic signed [15:0]           out_s,
  input  logic signed [15:0]           out_t,
  input  logic [1:0]                   corner,
  input  logic                         corner_kept,
  input  logic                         triangle_kept,
  input  logic                         last,
  input  logic                         cfg_valid,
  input  logic                         cfg_ready,
  input  logic                         cfg_index,
  input  logic [sfta_pkg::LIMIT_W-1:0] cfg_data,
  output int                           fail_count,
  output int                           pending
);

  typedef struct packed {
    logic [15:0]        vertex;
    logic [15:0]        normal;
    logic signed [15:0] s;
    logic signed [15:0] t;
    sfta_pkg::corner_t  pos;
    logic               kept;
    logic               tri_kept;
    logic               last;
  } corner_exp_t;

  corner_exp_t corners_due[$];

  // Shadow of the limit registers and the strip/fan assembly state
  logic [sfta_pkg::LIMIT_W-1:0] vertex_cap;
  logic [sfta_pkg::LIMIT_W-1:0] normal_cap;
  sfta_pkg::vrec_t              fan_root;
  sfta_pkg::vrec_t              prev2_rec;
  sfta_pkg::vrec_t              prev_rec;
  logic [16:0]                  verts_remaining;
  logic [15:0]                  group_pos;
  logic                         fan_group;
  int unsigned                  group_tally;
  logic                         mesh_halted;

  initial begin
    fail_count = 0;
    pending    = 0;
  end

  function automatic logic corner_ok(sfta_pkg::vrec_t r);
    return ({1'b0, r.vertex} < vertex_cap) && ({1'b0, r.normal} < normal_cap);
  endfunction

  // Queue the three corners of one triangle in output order
  task automatic queue_triangle(sfta_pkg::vrec_t a, sfta_pkg::vrec_t b,
                                sfta_pkg::vrec_t c);
    sfta_pkg::vrec_t trio [3];
    logic            all_ok;
    corner_exp_t     e;
    trio[0] = a;
    trio[1] = b;
    trio[2] = c;
    all_ok  = corner_ok(a) && corner_ok(b) && corner_ok(c);
    for (int k = 0; k < 3; k++) begin
      e.vertex   = trio[k].vertex;
      e.normal   = trio[k].normal;
      e.s        = trio[k].s;
      e.t        = trio[k].t;
      e.pos      = sfta_pkg::corner_t'(k);
      e.kept     = corner_ok(trio[k]);
      e.last     = (e.pos == sfta_pkg::CORNER_C);
      e.tri_kept = e.last && all_ok;
      corners_due.push_back(e);
    end
  endtask

  // Header: terminator, stopped mesh, or the start of a new strip or fan
  task automatic take_header(logic [15:0] count);
    if (count == 16'd0) begin
      group_tally     = 0;
      mesh_halted     = 1'b0;
      verts_remaining = '0;
      group_pos       = '0;
    end else if (mesh_halted || group_tally >= sfta_pkg::GROUP_LIMIT) begin
      mesh_halted     = 1'b1;
      verts_remaining = '0;
      group_pos       = '0;
    end else begin
      group_tally++;
      fan_group       = count[15];
      verts_remaining = fan_group ? 17'd65536 - {1'b0, count} : {1'b0, count};
      group_pos       = '0;
    end
  endtask

  // Command vertex: from the third vertex of a group on, close a triangle
  task automatic take_vertex(sfta_pkg::vrec_t r);
    if (!mesh_halted && verts_remaining != 0) begin
      if (group_pos == 0)
        fan_root = r;
      if (group_pos >= 2) begin
        if (fan_group)
          queue_triangle(fan_root, prev_rec, r);
        else if (!group_pos[0])
          queue_triangle(prev2_rec, prev_rec, r);
        else
          queue_triangle(prev_rec, prev2_rec, r);
      end
      prev2_rec = prev_rec;
      prev_rec  = r;
      group_pos = group_pos + 16'd1;
      verts_remaining--;
      if (verts_remaining == 0)
        group_pos = '0;
    end
  endtask

  task automatic check_field(string name, int want, int got);
    if (want != got) begin
      $error("%s: expected %0d, got %0d", name, want, got);
      fail_count++;
    end
  endtask

  // Compare corner transfers, track register writes, predict from commands
  always @(posedge clk) begin : watch_ports
    corner_exp_t     due;
    sfta_pkg::vrec_t rec;
    if (rst) begin
      vertex_cap      = 17'd65536;
      normal_cap      = 17'd65536;
      fan_root        = '0;
      prev2_rec       = '0;
      prev_rec        = '0;
      verts_remaining = '0;
      group_pos       = '0;
      fan_group       = 1'b0;
      group_tally     = 0;
      mesh_halted     = 1'b0;
      corners_due.delete();
    end else begin
      if (out_valid && !out_stall) begin
        if (corners_due.size() == 0) begin
          $error("corner transfer with no triangle pending");
          fail_count++;
        end else begin
          due = corners_due.pop_front();
          check_field("out_vertex", due.vertex, out_vertex);
          check_field("out_normal", due.normal, out_normal);
          check_field("out_s", due.s, out_s);
          check_field("out_t", due.t, out_t);
          check_field("corner", due.pos, corner);
          check_field("corner_kept", due.kept, corner_kept);
          check_field("triangle_kept", due.tri_kept, triangle_kept);
          check_field("last", due.last, last);
        end
      end
      if (cfg_valid && cfg_ready) begin
        if (sfta_pkg::reg_index_t'(cfg_index) == sfta_pkg::REG_VERTEX_LIMIT)
          vertex_cap = cfg_data;
        else
          normal_cap = cfg_data;
      end
      if (in_valid && !in_stall) begin
        if (sfta_pkg::cmd_t'(cmd) == sfta_pkg::CMD_HEADER) begin
          take_header(group_count);
        end else begin
          rec.vertex = vertex_id;
          rec.normal = normal_id;
          rec.s      = tex_s;
          rec.t      = tex_t;
          take_vertex(rec);
        end
      end
    end
    pending = corners_due.size();
  end

endmodule

>>> tb/strip_fan_triangle_assembler_top_tb.sv
// Testbench top for the strip/fan triangle assembler: clock, reset, command
// stimulus, corner back-pressure and the verdict. Depends on sfta_pkg, the
// assembler top level and sfta_corner_checker.
`timescale 1ns / 1ps

module strip_fan_triangle_assembler_top_tb;

  localparam int CYCLE_LIMIT = 1000000;
  localparam int HOLD_CYCLES = 120;
  localparam int DRAIN_CYCLES = 8;
  localparam int PHASE_ITEMS = 20;

  typedef struct {
    sfta_pkg::cmd_t  kind;
    logic [15:0]     count;
    sfta_pkg::vrec_t v;
  } cmd_item_t;

  logic                         clk;
  logic                         rst;
  logic                         in_valid;
  logic                         in_stall;
  logic                         cmd;
  logic signed [15:0]           group_count;
  logic [15:0]                  vertex_id;
  logic [15:0]                  normal_id;
  logic signed [15:0]           tex_s;
  logic signed [15:0]           tex_t;
  logic                         out_valid;
  logic                         out_stall;
  logic [15:0]                  out_vertex;
  logic [15:0]                  out_normal;
  logic signed [15:0]           out_s;
  logic signed [15:0]           out_t;
  logic [1:0]                   corner;
  logic                         corner_kept;
  logic                         triangle_kept;
  logic                         last;
  logic                         cfg_valid;
  logic                         cfg_ready;
  logic                         cfg_index;
  logic [sfta_pkg::LIMIT_W-1:0] cfg_data;
  int                           fail_count;
  int                           pending;

  cmd_item_t                    stream[$];
  logic [sfta_pkg::LIMIT_W-1:0] vert_cap;
  logic [sfta_pkg::LIMIT_W-1:0] norm_cap;
  bit                           calm = 1'b0;
  bit                           press_req = 1'b0;
  bit                           press_done = 1'b0;

  strip_fan_triangle_assembler_top uut (
    .clk          (clk),
    .rst          (rst),
    .in_valid     (in_valid),
    .in_stall     (in_stall),
    .cmd          (cmd),
    .group_count  (group_count),
    .vertex_id    (vertex_id),
    .normal_id    (normal_id),
    .tex_s        (tex_s),
    .tex_t        (tex_t),
    .out_valid    (out_valid),
    .out_stall    (out_stall),
    .out_vertex   (out_vertex),
    .out_normal   (out_normal),
    .out_s        (out_s),
    .out_t        (out_t),
    .corner       (corner),
    .corner_kept  (corner_kept),
    .triangle_kept(triangle_kept),
    .last         (last),
    .cfg_valid    (cfg_valid),
    .cfg_ready    (cfg_ready),
    .cfg_index    (cfg_index),
    .cfg_data     (cfg_data)
  );

  sfta_corner_checker corner_check (
    .clk          (clk),
    .rst          (rst),
    .in_valid     (in_valid),
    .in_stall     (in_stall),
    .cmd          (cmd),
    .group_count  (group_count),
    .vertex_id    (vertex_id),
    .normal_id    (normal_id),
    .tex_s        (tex_s),
    .tex_t        (tex_t),
    .out_valid    (out_valid),
    .out_stall    (out_stall),
    .out_vertex   (out_vertex),
    .out_normal   (out_normal),
    .out_s        (out_s),
    .out_t        (out_t),
    .corner       (corner),
    .corner_kept  (corner_kept),
    .triangle_kept(triangle_kept),
    .last         (last),
    .cfg_valid    (cfg_valid),
    .cfg_ready    (cfg_ready),
    .cfg_index    (cfg_index),
    .cfg_data     (cfg_data),
    .fail_count   (fail_count),
    .pending      (pending)
  );

  initial begin
    clk = 1'b0;
    forever #4 clk = ~clk;
  end

  // Abort a hung run
  initial begin
    repeat (CYCLE_LIMIT) @(posedge clk);
    $display("TB_ERROR");
    $finish;
  end

  // Corner receiver: random stall bursts, one long hold on request, none when calm
  initial begin
    out_stall = 1'b0;
    forever begin
      @(negedge clk);
      if (press_req && !press_done) begin
        out_stall <= 1'b1;
        repeat (HOLD_CYCLES - 1) @(negedge clk);
        press_done = 1'b1;
      end else if (!calm && $urandom_range(0, 3) == 0) begin
        out_stall <= 1'b1;
        repeat ($urandom_range(0, 8)) @(negedge clk);
      end else begin
        out_stall <= 1'b0;
        repeat ($urandom_range(0, 12)) @(negedge clk);
      end
    end
  end

  // Pick an index: zero, all ones, small, straddling the limit, or anything
  function automatic logic [15:0] pick_index(logic [sfta_pkg::LIMIT_W-1:0] cap);
    int near;
    case ($urandom_range(0, 5))
      0: return 16'h0000;
      1: return 16'hFFFF;
      2: return 16'($urandom_range(0, 15));
      3: begin
        near = int'(cap) + int'($urandom_range(0, 3)) - 2;
        if (near < 0)
          near = 0;
        if (near > 65535)
          near = 65535;
        return 16'(near);
      end
      default: return 16'($urandom);
    endcase
  endfunction

  function automatic sfta_pkg::vrec_t any_vertex();
    sfta_pkg::vrec_t r;
    r.vertex = pick_index(vert_cap);
    r.normal = pick_index(norm_cap);
    r.s      = 16'($urandom);
    r.t      = 16'($urandom);
    return r;
  endfunction

  function automatic sfta_pkg::vrec_t mk_vertex(logic [15:0] v, logic [15:0] n,
                                                logic [15:0] s, logic [15:0] t);
    sfta_pkg::vrec_t r;
    r.vertex = v;
    r.normal = n;
    r.s      = s;
    r.t      = t;
    return r;
  endfunction

  // Vertex fields of a header and the count of a vertex are don't-care: randomise
  task automatic add_header(logic [15:0] count);
    cmd_item_t it;
    it.kind  = sfta_pkg::CMD_HEADER;
    it.count = count;
    it.v     = {$urandom, $urandom};
    stream.push_back(it);
  endtask

  task automatic add_vertex(sfta_pkg::vrec_t r);
    cmd_item_t it;
    it.kind  = sfta_pkg::CMD_VERTEX;
    it.count = 16'($urandom);
    it.v     = r;
    stream.push_back(it);
  endtask

  // Mostly well-formed strips and fans, with cut groups, terminators and noise
  task automatic build_random(int n);
    int target;
    int len;
    int pick;
    target = stream.size() + n;
    while (stream.size() < target) begin
      pick = $urandom_range(0, 99);
      if (pick < 68) begin
        len = $urandom_range(1, 7);
        add_header($urandom_range(0, 1) ? 16'(-len) : 16'(len));
        repeat (len) add_vertex(any_vertex());
      end else if (pick < 76) begin
        len = $urandom_range(4, 9);
        add_header($urandom_range(0, 1) ? 16'(-len) : 16'(len));
        repeat ($urandom_range(0, len - 1)) add_vertex(any_vertex());
      end else if (pick < 83) begin
        add_header(16'd0);
      end else if (pick < 89) begin
        add_vertex(any_vertex());
      end else if (pick < 95) begin
        add_header(16'($urandom_range(1, 65535)));
        repeat ($urandom_range(2, 6)) add_vertex(any_vertex());
      end else if ($urandom_range(0, 1)) begin
        add_header(16'($urandom));
      end else begin
        add_vertex({$urandom, $urandom});
      end
    end
  endtask

  // Drive the queued commands; entered and left at a falling edge
  task automatic run_stream();
    cmd_item_t it;
    while (stream.size() > 0) begin
      it = stream.pop_front();
      if (!calm && $urandom_range(0, 3) == 0) begin
        in_valid <= 1'b0;
        repeat ($urandom_range(1, 9)) @(negedge clk);
      end
      cmd         <= it.kind;
      group_count <= it.count;
      vertex_id   <= it.v.vertex;
      normal_id   <= it.v.normal;
      tex_s       <= it.v.s;
      tex_t       <= it.v.t;
      in_valid    <= 1'b1;
      do @(posedge clk); while (in_stall);
      @(negedge clk);
    end
    in_valid <= 1'b0;
  endtask

  // Wait for every corner, then let a command still inside the block finish
  task automatic settle();
    wait (pending == 0);
    repeat (DRAIN_CYCLES) @(negedge clk);
  endtask

  task automatic write_limit(sfta_pkg::reg_index_t idx,
                             logic [sfta_pkg::LIMIT_W-1:0] value);
    @(negedge clk);
    cfg_valid <= 1'b1;
    cfg_index <= idx;
    cfg_data  <= value;
    do @(posedge clk); while (!cfg_ready);
    @(negedge clk);
    cfg_valid <= 1'b0;
    if (idx == sfta_pkg::REG_VERTEX_LIMIT)
      vert_cap = value;
    else
      norm_cap = value;
  endtask

  task automatic set_limits(logic [sfta_pkg::LIMIT_W-1:0] v,
                            logic [sfta_pkg::LIMIT_W-1:0] n);
    write_limit(sfta_pkg::REG_VERTEX_LIMIT, v);
    write_limit(sfta_pkg::REG_NORMAL_LIMIT, n);
  endtask

  initial begin
    rst         = 1'b1;
    in_valid    = 1'b0;
    cmd         = sfta_pkg::CMD_HEADER;
    group_count = '0;
    vertex_id   = '0;
    normal_id   = '0;
    tex_s       = '0;
    tex_t       = '0;
    cfg_valid   = 1'b0;
    cfg_index   = sfta_pkg::REG_VERTEX_LIMIT;
    cfg_data    = '0;
    vert_cap    = 17'd65536;
    norm_cap    = 17'd65536;
    repeat (9) @(posedge clk);
    @(negedge clk);
    rst <= 1'b0;

    // Directed commands under the reset limits
    add_vertex(mk_vertex(16'hFFFF, 16'hFFFF, 16'h7FFF, 16'h8000));  // stray vertex
    add_header(16'd5);                                              // strip, both parities
    add_vertex(mk_vertex(16'h0000, 16'h0000, 16'h8000, 16'h7FFF));
    add_vertex(mk_vertex(16'hFFFF, 16'hFFFF, 16'h7FFF, 16'h8000));
    add_vertex(mk_vertex(16'd1, 16'd2, 16'd3, 16'd4));
    add_vertex(mk_vertex(16'd5, 16'd6, 16'hFFF9, 16'hFFF8));
    add_vertex(mk_vertex(16'd9, 16'd10, 16'd11, 16'd12));
    add_header(16'hFFFC);                                           // fan of four
    repeat (4) add_vertex(any_vertex());
    add_header(16'hFFFE);                                           // short fan
    repeat (2) add_vertex(any_vertex());
    add_header(16'd6);                                              // cut by next header
    repeat (3) add_vertex(any_vertex());
    add_header(16'h8000);                                           // longest fan, cut
    repeat (3) add_vertex(any_vertex());
    add_header(16'h7FFF);                                           // longest strip, cut
    add_header(16'd0);
    add_vertex(any_vertex());
    run_stream();
    settle();

    // Random phases over a spread of limit settings
    for (int p = 0; p < 7; p++) begin
      case (p)
        0: set_limits(17'd65535, 17'd65535);
        1: set_limits(17'd0, 17'd65536);
        2: set_limits(17'd65536, 17'd0);
        3: set_limits(17'd1, 17'd1);
        4: set_limits(17'h1FFFF, 17'h1FFFF);
        5: set_limits(17'($urandom_range(2, 300)), 17'($urandom_range(2, 300)));
        default: set_limits(17'($urandom_range(1, 65536)), 17'($urandom_range(1, 65536)));
      endcase
      // fill the block against a long output hold
      if (p == 4)
        press_req = 1'b1;
      build_random(PHASE_ITEMS);
      run_stream();
      settle();
    end

    // Last part without idling
    calm = 1'b1;
    build_random(PHASE_ITEMS);
    run_stream();
    settle();

    if (fail_count == 0)
      $display("TB_OK");
    else
      $display("TB_ERROR");
    $finish;
  end

endmodule

>>> strip_fan_triangle_assembler_top.f
src/sfta_pkg.sv
src/sfta_front.sv
src/sfta_queue.sv
src/sfta_back.sv
src/strip_fan_triangle_assembler_top.sv
tb/sfta_corner_checker.sv
tb/strip_fan_triangle_assembler_top_tb.sv
